FILE: design/nmea_enc_pkg.sv
// package for the nmea-style sentence encoder
// holds sizes, ascii codes, register indexes and helper functions
// used by the encoder top level and its checker
package nmea_enc_pkg;

  localparam int unsigned MAX_VALUES = 6;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned HDR_W      = 40;
  localparam int unsigned HDR_BYTES  = HDR_W / 8;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned VIDX_W     = $clog2(MAX_VALUES + 1);
  localparam int unsigned NDIG       = 5;
  localparam int unsigned BCD_W      = 4 * NDIG;
  localparam int unsigned DIDX_W     = $clog2(NDIG);
  localparam int unsigned STEP_W     = $clog2(VAL_W);
  localparam int unsigned HCNT_W     = $clog2(HDR_BYTES);

  // register indexes
  localparam logic REG_HDR0 = 1'b0;
  localparam logic REG_HDR1 = 1'b1;

  // header reset values, "SFIMU" and "SFMAG"
  localparam logic [HDR_W-1:0] HDR0_RST = 40'h5346494D55;
  localparam logic [HDR_W-1:0] HDR1_RST = 40'h53464D4147;

  // ascii codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // upper-case hex character of one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'd0, nib};
    end else begin
      r = CH_UPPER_A + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

  // one double-dabble step: add 3 to every digit of 5 or more
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] r;
    r = bcd;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        r[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // index of the leading nonzero digit, zero when all digits are zero
  function automatic logic [DIDX_W-1:0] lead_digit(input logic [BCD_W-1:0] bcd);
    logic [DIDX_W-1:0] r;
    r = '0;
    for (int k = 0; k < NDIG; k++) begin
      if (bcd[4*k +: 4] != 4'd0) begin
        r = DIDX_W'(k);
      end
    end
    return r;
  endfunction

endpackage

FILE: design/nmea_style_sentence_encoder_unit.sv
// once start is taken, the first byte goes through the state register and then the output register;
// after it one byte per cycle, except a gap per value while the shared double-dabble unit converts it;
// the gap is shorter when a minus sign goes out during the first conversion step
// busy is high for the whole item, so a new start is taken only once the line feed is shown
// results cannot be stalled; bytes leave through a registered output stage
// reset (rst_ni low, async) returns to idle and loads the default headers
// top level of the nmea-style sentence encoder, depends on nmea_enc_pkg
// sequencer, shared bcd converter, checksum and output register
module nmea_style_sentence_encoder_unit
  import nmea_enc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    sentence_kind_i,
  input  logic [CNT_W-1:0]        value_count_i,
  input  logic signed [VAL_W-1:0] value_0_i,
  input  logic signed [VAL_W-1:0] value_1_i,
  input  logic signed [VAL_W-1:0] value_2_i,
  input  logic signed [VAL_W-1:0] value_3_i,
  input  logic signed [VAL_W-1:0] value_4_i,
  input  logic signed [VAL_W-1:0] value_5_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_index_i,
  input  logic [HDR_W-1:0]        cfg_data_i,
  output logic                    out_strobe_o,
  output logic [7:0]              out_char_o,
  output logic                    last_char_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DOLLAR = 12'b0000_0000_0010,
    S_HDR    = 12'b0000_0000_0100,
    S_COMMA  = 12'b0000_0000_1000,
    S_SIGN   = 12'b0000_0001_0000,
    S_CONV   = 12'b0000_0010_0000,
    S_DIGIT  = 12'b0000_0100_0000,
    S_STAR   = 12'b0000_1000_0000,
    S_HEXHI  = 12'b0001_0000_0000,
    S_HEXLO  = 12'b0010_0000_0000,
    S_CR     = 12'b0100_0000_0000,
    S_LF     = 12'b1000_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [HDR_W-1:0]        hdr0_q, hdr1_q;
  logic [HDR_W-1:0]        hdr_q, hdr_d;
  logic [HCNT_W-1:0]       hcnt_q, hcnt_d;
  logic [VIDX_W-1:0]       cnt_q, cnt_d;
  logic [VIDX_W-1:0]       vidx_q, vidx_d;
  logic [VAL_W-1:0]        vals_q [MAX_VALUES];
  logic [VAL_W-1:0]        bin_q, bin_d;
  logic [BCD_W-1:0]        bcd_q, bcd_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [DIDX_W-1:0]       didx_q, didx_d;
  logic [7:0]              chk_q, chk_d;
  logic [7:0]              char_q, char_d;
  logic                    strobe_q, strobe_d;
  logic                    last_q, last_d;
  logic                    accept;
  logic                    in_sum;
  logic [VAL_W-1:0]        cur_val;
  logic [BCD_W-1:0]        bcd_adj;
  logic [VIDX_W-1:0]       vidx_inc;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q <= HDR0_RST;
      hdr1_q <= HDR1_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_HDR0: hdr0_q <= cfg_data_i;
        REG_HDR1: hdr1_q <= cfg_data_i;
        default:  hdr0_q <= hdr0_q;
      endcase
    end
  end

  // capture the item's values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vals_q[0] <= value_0_i;
      vals_q[1] <= value_1_i;
      vals_q[2] <= value_2_i;
      vals_q[3] <= value_3_i;
      vals_q[4] <= value_4_i;
      vals_q[5] <= value_5_i;
    end
  end

  assign cur_val  = vals_q[vidx_q[VIDX_W-1:0] < VIDX_W'(MAX_VALUES) ?
                           vidx_q : VIDX_W'(0)];
  assign bcd_adj  = bcd_adjust(bcd_q);
  assign vidx_inc = vidx_q + VIDX_W'(1);

  // sequencer
  always_comb begin
    state_d  = state_q;
    hdr_d    = hdr_q;
    hcnt_d   = hcnt_q;
    cnt_d    = cnt_q;
    vidx_d   = vidx_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    step_d   = step_q;
    didx_d   = didx_q;
    char_d   = CH_ZERO;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    in_sum   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          hdr_d  = sentence_kind_i ? hdr1_q : hdr0_q;
          cnt_d  = (value_count_i > CNT_W'(MAX_VALUES)) ? VIDX_W'(MAX_VALUES)
                                                          : VIDX_W'(value_count_i);
          vidx_d = '0;
          hcnt_d = '0;
          state_d = S_DOLLAR;
        end
      end
      S_DOLLAR: begin
        char_d   = CH_DOLLAR;
        strobe_d = 1'b1;
        state_d  = S_HDR;
      end
      S_HDR: begin
        char_d   = hdr_q[HDR_W-1 -: 8];
        strobe_d = 1'b1;
        in_sum   = 1'b1;
        hdr_d    = {hdr_q[HDR_W-9:0], 8'd0};
        hcnt_d   = hcnt_q + HCNT_W'(1);
        if (hcnt_q == HCNT_W'(HDR_BYTES - 1)) begin
          state_d = (cnt_q == '0) ? S_STAR : S_COMMA;
        end
      end
      S_COMMA: begin
        char_d   = CH_COMMA;
        strobe_d = 1'b1;
        in_sum   = 1'b1;
        bin_d    = cur_val[VAL_W-1] ? (~cur_val + VAL_W'(1)) : cur_val;
        bcd_d    = '0;
        step_d   = '0;
        state_d  = cur_val[VAL_W-1] ? S_SIGN : S_CONV;
      end
      S_SIGN: begin
        char_d   = CH_MINUS;
        strobe_d = 1'b1;
        in_sum   = 1'b1;
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        step_d   = step_q + STEP_W'(1);
        state_d  = S_CONV;
      end
      S_CONV: begin
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        step_d   = step_q + STEP_W'(1);
        if (step_q == STEP_W'(VAL_W - 1)) begin
          didx_d  = lead_digit(bcd_d);
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        char_d   = CH_ZERO + {4'd0, bcd_q[4*didx_q +: 4]};
        strobe_d = 1'b1;
        in_sum   = 1'b1;
        if (didx_q == '0) begin
          vidx_d  = vidx_inc;
          state_d = (vidx_inc == cnt_q) ? S_STAR : S_COMMA;
        end else begin
          didx_d = didx_q - DIDX_W'(1);
        end
      end
      S_STAR: begin
        char_d   = CH_STAR;
        strobe_d = 1'b1;
        state_d  = S_HEXHI;
      end
      S_HEXHI: begin
        char_d   = hex_char(chk_q[7:4]);
        strobe_d = 1'b1;
        state_d  = S_HEXLO;
      end
      S_HEXLO: begin
        char_d   = hex_char(chk_q[3:0]);
        strobe_d = 1'b1;
        state_d  = S_CR;
      end
      S_CR: begin
        char_d   = CH_CR;
        strobe_d = 1'b1;
        state_d  = S_LF;
      end
      S_LF: begin
        char_d   = CH_LF;
        strobe_d = 1'b1;
        last_d   = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // running checksum over the bytes between '$' and '*'
  always_comb begin
    chk_d = chk_q;
    if (accept) begin
      chk_d = '0;
    end else if (in_sum) begin
      chk_d = chk_q ^ char_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hcnt_q   <= '0;
      cnt_q    <= '0;
      vidx_q   <= '0;
      step_q   <= '0;
      didx_q   <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      hcnt_q   <= hcnt_d;
      cnt_q    <= cnt_d;
      vidx_q   <= vidx_d;
      step_q   <= step_d;
      didx_q   <= didx_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    hdr_q  <= hdr_d;
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    chk_q  <= chk_d;
    char_q <= char_d;
  end

  assign out_strobe_o = strobe_q;
  assign out_char_o   = char_q;
  assign last_char_o  = last_q;

endmodule

FILE: design/nmea_enc_checker.sv
// port-level checker for the nmea-style sentence encoder
// depends on nmea_enc_pkg, bound to nmea_style_sentence_encoder_unit
module nmea_enc_checker
  import nmea_enc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       out_strobe_o,
  input logic [7:0] out_char_o,
  input logic       last_char_o
);

  // a taken item makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not set after start");

  // every sentence opens with a strobed '$' after a taken start
  a_dollar_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 (out_strobe_o && (out_char_o == CH_DOLLAR)))
    else $error("sentence does not open with dollar");

  // last marks a strobed line feed
  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> (out_strobe_o && (out_char_o == CH_LF)))
    else $error("last flag not on a line feed");

  // busy drops exactly as the final line feed is shown
  a_end_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> last_char_o)
    else $error("busy fell without final line feed");

endmodule

bind nmea_style_sentence_encoder_unit nmea_enc_checker u_nmea_enc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .out_strobe_o(out_strobe_o),
  .out_char_o  (out_char_o),
  .last_char_o (last_char_o)
);
